@@ rtl/byte_pattern_scanner_macros.svh @@
// assertion macros for the byte pattern scanner
// no dependencies; included by the top level only
`ifndef BYTE_PATTERN_SCANNER_MACROS_SVH
`define BYTE_PATTERN_SCANNER_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define BPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// cause in this cycle, effect in the next one
`define BPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define BPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/bps_pkg.sv @@
// shared constants, codes and types of the byte pattern scanner
// no dependencies; imported by bps_cell, bps_align and byte_pattern_scanner
package bps_pkg;

    localparam int MAX_PATTERN_DEF = 64;

    localparam int OP_W      = 1;
    localparam int IDX_W     = 6;
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 7;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    // input tdata layout
    localparam int TD_IDX_LSB  = 0;
    localparam int TD_BYTE_LSB = TD_IDX_LSB + IDX_W;
    localparam int TD_ADDR_LSB = TD_BYTE_LSB + BYTE_W;

    // input tuser layout
    localparam int TU_OP_BIT    = 0;
    localparam int TU_CHUNK_BIT = 1;

    typedef enum logic [OP_W-1:0] {
        OP_PAT_WRITE = 1'b0,
        OP_SCAN      = 1'b1
    } t_op;

    typedef struct packed {
        logic shift_en;   // window moves by one byte
        logic cmp_en;     // compare stage advances
    } t_cell_ctrl;

endpackage

@@ rtl/bps_cell.sv @@
// one cell of the scan chain: window byte, fill bit, pattern byte, compare flop
// depends on bps_pkg
module bps_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bps_pkg::t_cell_ctrl        i_ctrl,
    input  logic [bps_pkg::BYTE_W-1:0] i_prev_byte,
    input  logic                       i_prev_valid,
    input  logic                       i_pat_we,
    input  logic [bps_pkg::BYTE_W-1:0] i_pat_byte,
    input  logic [bps_pkg::BYTE_W-1:0] i_ref_byte,
    input  logic                       i_ref_en,
    output logic [bps_pkg::BYTE_W-1:0] o_byte,
    output logic                       o_valid,
    output logic [bps_pkg::BYTE_W-1:0] o_pat_byte,
    output logic                       o_hit
);
    import bps_pkg::*;

    logic [BYTE_W-1:0] r_byte;
    logic              r_valid;
    logic [BYTE_W-1:0] r_pat;
    logic              r_hit;
    logic              n_hit;

    // lanes beyond the pattern length always agree
    assign n_hit = !i_ref_en || (r_valid && (r_byte == i_ref_byte));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift_en) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_en) begin
            r_byte <= i_prev_byte;
        end
        if (i_pat_we) begin
            r_pat <= i_pat_byte;
        end
        if (i_ctrl.cmp_en) begin
            r_hit <= n_hit;
        end
    end

    assign o_byte     = r_byte;
    assign o_valid    = r_valid;
    assign o_pat_byte = r_pat;
    assign o_hit      = r_hit;

endmodule

@@ rtl/bps_align.sv @@
// lines the pattern up with window ages: lane a gets pattern byte (len-1-a)
// depends on bps_pkg
module bps_align #(
    parameter int MAX_PATTERN = bps_pkg::MAX_PATTERN_DEF,
    parameter int AW          = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic [MAX_PATTERN*bps_pkg::BYTE_W-1:0] i_pat,
    input  logic [AW-1:0]                          i_len_m1,
    output logic [MAX_PATTERN*bps_pkg::BYTE_W-1:0] o_ref,
    output logic [MAX_PATTERN-1:0]                 o_ref_en
);
    import bps_pkg::*;

    logic [MAX_PATTERN*BYTE_W-1:0] w_rev;
    logic [AW-1:0]                 w_shamt;

    // reversed pattern, then shifted down by (max - len) bytes
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_rev
        assign w_rev[j*BYTE_W +: BYTE_W] = i_pat[(MAX_PATTERN-1-j)*BYTE_W +: BYTE_W];
        assign o_ref_en[j] = (AW'(j) <= i_len_m1);
    end

    assign w_shamt = AW'(MAX_PATTERN - 1) - i_len_m1;
    assign o_ref   = w_rev >> {w_shamt, 3'b000};

endmodule

@@ rtl/byte_pattern_scanner.sv @@
// byte_pattern_scanner: exact byte pattern search over a stream of memory bytes
// depends on bps_pkg, bps_cell, bps_align and byte_pattern_scanner_macros.svh
//
//  channel | dir | handshake                    | payload
//  --------+-----+------------------------------+---------------------------------------
//  s_axis  | in  | s_axis_tvalid/s_axis_tready  | tdata: idx, byte, addr; tuser: op, chunk
//  m_axis  | out | m_axis_tvalid/m_axis_tready  | tdata: match_address
//  cfg     | in  | i_cfg_we (no back-pressure)  | i_cfg_wdata: pattern_length
//
// one transaction per cycle in sustained flow unless a result waits for the sink;
// a match passes window shift, per-cell compare and and-reduce into the output flop
// synchronous active-low reset clears fill bits, pipeline valids and sets length 1;
// the pattern store is not reset and must be written before it is used
// s_axis_tready drops only while the output register holds an untaken result;
// the whole chain freezes then, so nothing is lost or repeated
`include "byte_pattern_scanner_macros.svh"

module byte_pattern_scanner #(
    parameter int MAX_PATTERN = bps_pkg::MAX_PATTERN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: pattern_length
    input  logic                          i_cfg_we,
    input  logic [bps_pkg::LEN_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [5:0] pattern_index, [13:6] byte_value, [45:14] byte_address, [47:46] zero
    input  logic [bps_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] operation, [1] chunk_start
    input  logic [bps_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] match_address
    output logic [bps_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import bps_pkg::*;

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // input field unpacking
    t_op               w_op;
    logic [IDX_W-1:0]  w_idx;
    logic [BYTE_W-1:0] w_byte;
    logic [ADDR_W-1:0] w_addr;
    logic              w_chunk;

    // handshake and pipeline control
    logic       w_en;
    logic       w_acc;
    logic       w_scan;
    logic       w_pwr;
    t_cell_ctrl w_ctrl;

    // configuration: effective length minus one
    logic [AW-1:0] r_len_m1;
    logic [AW-1:0] n_len_m1;

    // chain buses, one lane per cell
    logic [MAX_PATTERN*BYTE_W-1:0] w_win_byte;
    logic [MAX_PATTERN-1:0]        w_valid;
    logic [MAX_PATTERN*BYTE_W-1:0] w_pat_vec;
    logic [MAX_PATTERN*BYTE_W-1:0] w_ref_vec;
    logic [MAX_PATTERN-1:0]        w_ref_en;
    logic [MAX_PATTERN-1:0]        w_hit;

    // pipeline stages
    logic              r_s1_valid;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s2_valid;
    logic [ADDR_W-1:0] r_s2_addr;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;

    assign w_op    = t_op'(s_axis_tuser[TU_OP_BIT]);
    assign w_chunk = s_axis_tuser[TU_CHUNK_BIT];
    assign w_idx   = s_axis_tdata[TD_IDX_LSB  +: IDX_W];
    assign w_byte  = s_axis_tdata[TD_BYTE_LSB +: BYTE_W];
    assign w_addr  = s_axis_tdata[TD_ADDR_LSB +: ADDR_W];

    // everything advances unless a finished result waits for the sink
    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_acc         = s_axis_tvalid && w_en;
    assign w_scan        = w_acc && (w_op == OP_SCAN);
    assign w_pwr         = w_acc && (w_op == OP_PAT_WRITE);

    assign w_ctrl.shift_en = w_scan;
    assign w_ctrl.cmp_en   = w_en;

    // length zero acts as one, lengths above the store saturate
    always_comb begin
        if (32'(i_cfg_wdata) > 32'(MAX_PATTERN)) begin
            n_len_m1 = AW'(MAX_PATTERN - 1);
        end else if (i_cfg_wdata == '0) begin
            n_len_m1 = '0;
        end else begin
            n_len_m1 = AW'(i_cfg_wdata - LEN_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_m1 <= '0;
        end else if (i_cfg_we) begin
            r_len_m1 <= n_len_m1;
        end
    end

    // cell k holds the window byte of age k; new byte enters cell 0.
    // a chunk start keeps only the new byte valid
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic [BYTE_W-1:0] w_prev_byte;
        logic              w_prev_valid;
        logic              w_pat_we;

        if (k == 0) begin : g_head
            assign w_prev_byte  = w_byte;
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_byte  = w_win_byte[(k-1)*BYTE_W +: BYTE_W];
            assign w_prev_valid = w_valid[k-1] && !w_chunk;
        end

        // an index past the store matches no cell and is dropped
        assign w_pat_we = w_pwr && (32'(w_idx) == 32'(k));

        bps_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_prev_byte  (w_prev_byte),
            .i_prev_valid (w_prev_valid),
            .i_pat_we     (w_pat_we),
            .i_pat_byte   (w_byte),
            .i_ref_byte   (w_ref_vec[k*BYTE_W +: BYTE_W]),
            .i_ref_en     (w_ref_en[k]),
            .o_byte       (w_win_byte[k*BYTE_W +: BYTE_W]),
            .o_valid      (w_valid[k]),
            .o_pat_byte   (w_pat_vec[k*BYTE_W +: BYTE_W]),
            .o_hit        (w_hit[k])
        );
    end

    // pattern byte (len-1-a) is routed to the cell holding age a
    bps_align #(
        .MAX_PATTERN (MAX_PATTERN),
        .AW          (AW)
    ) u_align (
        .i_pat    (w_pat_vec),
        .i_len_m1 (r_len_m1),
        .o_ref    (w_ref_vec),
        .o_ref_en (w_ref_en)
    );

    // stage 1: window shifted; stage 2: cell hits registered; out: all lanes agree
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid  <= w_scan;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && (&w_hit);
        end
    end

    // start address of the match, modulo 2^32
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_addr  <= w_addr;
            r_s2_addr  <= r_s1_addr - ADDR_W'(r_len_m1);
            r_out_addr <= r_s2_addr;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_addr;

    // a scanned byte always enters the compare pipeline
    `BPS_ASSERT_NEXT(a_scan_enters, i_clk, i_rst_n, w_scan, r_s1_valid, "scan byte lost")
    // a pattern write never starts a compare
    `BPS_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, w_pwr, !r_s1_valid, "pattern write compared")
    // valid window bytes form an unbroken run from the newest one
    `BPS_ASSERT(a_valid_prefix, i_clk, i_rst_n, (w_valid & (w_valid + MAX_PATTERN'(1))) == '0, "window fill bits not contiguous")
    // effective length never exceeds the store
    `BPS_ASSERT(a_len_range, i_clk, i_rst_n, r_len_m1 <= AW'(MAX_PATTERN - 1), "length beyond store")

endmodule

@@ tb/tb_byte_pattern_scanner.sv @@
`timescale 1ns / 1ps
// self-checking testbench for byte_pattern_scanner: pattern loads, chunked scans, stalls
// depends on bps_pkg and the byte_pattern_scanner rtl; match addresses are predicted in-line
module tb_byte_pattern_scanner;
    import bps_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int DEPTH          = MAX_PATTERN_DEF;
    localparam int DRAIN_CYCLES   = 8;       // three-stage pipe plus margin
    localparam int RANDOM_ITEMS   = 60;
    localparam int MAX_REPORTS    = 10;
    localparam int TIMEOUT_CYCLES = 250000;
    localparam int HOLD_CYCLES    = 150;     // long receiver stall for the pressure test

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [LEN_W-1:0]     i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // scanner model state, mirrored from what the block has accepted
    logic [BYTE_W-1:0] pat_mem [DEPTH];
    logic [BYTE_W-1:0] win [DEPTH];          // entry 0 holds the newest data byte
    int                fill;
    logic [LEN_W-1:0]  len_reg;
    logic [ADDR_W-1:0] pending_match_addr [$];

    int  err_count    = 0;
    int  items_sent   = 0;
    int  sink_hold    = 0;
    bit  src_idle_en  = 1'b1;
    bit  sink_idle_en = 1'b1;
    logic [ADDR_W-1:0] want_addr;

    byte_pattern_scanner uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // length in use: zero acts as one, anything past the store depth saturates
    function automatic int eff_len(input logic [LEN_W-1:0] v);
        if (v == 0) return 1;
        if (v > DEPTH) return DEPTH;
        return int'(v);
    endfunction

    // update the scanner state for one accepted transaction, queue a match if one is found
    function automatic void predict_match(input t_op op, input logic [IDX_W-1:0] idx,
                                          input logic [BYTE_W-1:0] val,
                                          input logic [ADDR_W-1:0] addr, input logic chunk);
        int n;
        bit hit;
        if (op == OP_PAT_WRITE) begin
            pat_mem[idx] = val;
            return;
        end
        if (chunk) fill = 0;
        for (int k = DEPTH - 1; k > 0; k--) win[k] = win[k - 1];
        win[0] = val;
        if (fill < DEPTH) fill++;
        n = eff_len(len_reg);
        if (fill < n) return;
        hit = 1'b1;
        // oldest byte of the candidate lines up with pattern entry 0
        for (int k = 0; k < n; k++)
            if (win[n - 1 - k] !== pat_mem[k]) hit = 1'b0;
        if (hit) pending_match_addr.push_back(addr - ADDR_W'(n - 1));
    endfunction

    task automatic flag_error(input string what);
        err_count++;
        if (err_count <= MAX_REPORTS) $display("[%0t] %s", $time, what);
    endtask

    // offer one transaction after a random gap and hold it until the block takes it
    task automatic send_item(input t_op op, input logic [IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] val, input logic [ADDR_W-1:0] addr,
                             input logic chunk);
        int gap;
        logic [S_TDATA_W-1:0] td;
        logic [S_TUSER_W-1:0] tu;
        gap = src_idle_en ? $urandom_range(0, 3) : 0;
        td = '0;
        td[TD_IDX_LSB +: IDX_W]   = idx;
        td[TD_BYTE_LSB +: BYTE_W] = val;
        td[TD_ADDR_LSB +: ADDR_W] = addr;
        tu = '0;
        tu[TU_OP_BIT]    = op;
        tu[TU_CHUNK_BIT] = chunk;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= td;
        s_axis_tuser  <= tu;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_match(op, idx, val, addr, chunk);
        items_sent++;
    endtask

    // drop valid, let every expected match come out, then let the pipe empty
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_match_addr.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_len(input logic [LEN_W-1:0] v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        len_reg = v;
    endtask

    // fill pattern entries 0..n-1, sometimes from a tiny alphabet so noise hits too
    task automatic load_pattern(input int n);
        bit narrow;
        logic [BYTE_W-1:0] v;
        narrow = ($urandom_range(0, 2) == 0);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 3))
                0:       v = 8'h00;
                1:       v = 8'hFF;
                default: v = narrow ? 8'h5A : BYTE_W'($urandom);
            endcase
            if (!narrow) v = BYTE_W'($urandom);
            send_item(OP_PAT_WRITE, IDX_W'(k), v, ADDR_W'($urandom), 1'($urandom));
        end
    endtask

    // one chunk of n data bytes with rising addresses; planted copies of the pattern,
    // some of them one byte off, plus the odd mid-chunk restart, address jump and
    // pattern write slipped in between
    task automatic scan_chunk(input int n, input logic [ADDR_W-1:0] base);
        logic [BYTE_W-1:0] chunk_bytes [$];
        logic [ADDR_W-1:0] a;
        int len, plants, pos;
        len = eff_len(len_reg);
        for (int k = 0; k < n; k++)
            chunk_bytes.push_back($urandom_range(0, 1) ? pat_mem[$urandom_range(0, len - 1)]
                                                       : BYTE_W'($urandom));
        plants = (n >= len) ? $urandom_range(1, n / len) : 0;
        for (int j = 0; j < plants; j++) begin
            pos = $urandom_range(0, n - len);
            for (int k = 0; k < len; k++) chunk_bytes[pos + k] = pat_mem[k];
            if ($urandom_range(0, 3) == 0) begin
                pos = pos + $urandom_range(0, len - 1);
                chunk_bytes[pos] = ~chunk_bytes[pos];
            end
        end
        a = base;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 29) == 0)
                send_item(OP_PAT_WRITE, IDX_W'($urandom), BYTE_W'($urandom),
                          ADDR_W'($urandom), 1'($urandom));
            if ($urandom_range(0, 49) == 0) a = ADDR_W'($urandom);
            send_item(OP_SCAN, IDX_W'($urandom), chunk_bytes[k], a,
                      (k == 0) || ($urandom_range(0, 39) == 0));
            a = a + 1'b1;
        end
    endtask

    // length one and length zero, addresses at both ends
    task automatic test_single_byte();
        write_len(7'd1);
        send_item(OP_PAT_WRITE, 6'd0, 8'h00, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_SCAN, 6'd63, 8'h00, 32'h0000_0000, 1'b1);
        send_item(OP_SCAN, 6'd0, 8'hFF, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_SCAN, 6'd21, 8'h00, 32'hFFFF_FFFF, 1'b0);
        write_len(7'd0);
        send_item(OP_SCAN, 6'd42, 8'h00, 32'h8000_0000, 1'b1);
        send_item(OP_SCAN, 6'd63, 8'h01, 32'h8000_0001, 1'b0);
    endtask

    // three-byte pattern: plain hit, address wrap, chunk restart, falling addresses
    task automatic test_multi_byte();
        send_item(OP_PAT_WRITE, 6'd1, 8'hFF, 32'h0, 1'b0);
        send_item(OP_PAT_WRITE, 6'd2, 8'hA5, 32'h0, 1'b0);
        write_len(7'd3);
        send_item(OP_SCAN, 6'd0, 8'h00, 32'd1, 1'b1);
        send_item(OP_SCAN, 6'd0, 8'hFF, 32'd2, 1'b0);
        send_item(OP_SCAN, 6'd0, 8'hA5, 32'd3, 1'b0);
        // start address of the match wraps below zero
        send_item(OP_SCAN, 6'd7, 8'h00, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_SCAN, 6'd7, 8'hFF, 32'h0000_0000, 1'b0);
        // pattern write in the middle of a candidate leaves the window alone
        send_item(OP_PAT_WRITE, 6'd63, 8'h5A, 32'h1234_5678, 1'b1);
        send_item(OP_SCAN, 6'd7, 8'hA5, 32'h0000_0001, 1'b0);
        // restart on the last byte: no match across the chunk boundary
        send_item(OP_SCAN, 6'd0, 8'h00, 32'd10, 1'b1);
        send_item(OP_SCAN, 6'd0, 8'hFF, 32'd11, 1'b0);
        send_item(OP_SCAN, 6'd0, 8'hA5, 32'd12, 1'b1);
        // addresses that fall: same address formula anyway
        send_item(OP_SCAN, 6'd0, 8'h00, 32'd100, 1'b1);
        send_item(OP_SCAN, 6'd0, 8'hFF, 32'd50, 1'b0);
        send_item(OP_SCAN, 6'd0, 8'hA5, 32'd7, 1'b0);
    endtask

    // whole store in use, reached through saturation and through the exact depth
    task automatic test_full_length();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        write_len(7'd127);
        load_pattern(DEPTH);
        scan_chunk(DEPTH + 20, 32'hFFFF_FFE0);
        write_len(7'd65);
        scan_chunk(DEPTH, ADDR_W'($urandom));
        write_len(7'd64);
        scan_chunk(DEPTH + 30, ADDR_W'($urandom));
    endtask

    // receiver stalls for a long stretch while bytes keep coming, so the input stalls
    task automatic test_backpressure();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        write_len(7'd1);
        send_item(OP_PAT_WRITE, 6'd0, 8'h3C, ADDR_W'($urandom), 1'b0);
        sink_hold = HOLD_CYCLES;
        for (int k = 0; k < 48; k++)
            send_item(OP_SCAN, IDX_W'($urandom), (k % 5 == 4) ? 8'hC3 : 8'h3C,
                      32'h0000_1000 + k, k == 0);
    endtask

    // random phases: new length, fresh pattern, a few chunks; mostly short patterns
    task automatic test_random_scan();
        int start_count, pick, len;
        logic [LEN_W-1:0] v;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                v = 7'd0;
            else if (pick == 1)
                v = LEN_W'($urandom_range(DEPTH, 127));
            else if (pick < 5)
                v = LEN_W'($urandom_range(9, 16));
            else
                v = LEN_W'($urandom_range(1, 8));
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            write_len(v);
            len = eff_len(v);
            load_pattern(len);
            repeat ($urandom_range(2, 4))
                scan_chunk($urandom_range(len, (len > 16) ? len + 24 : 3 * len + 8),
                           ADDR_W'($urandom));
        end
    endtask

    // receiver: random stall before each result, or one long hold when requested
    initial begin : result_sink
        int gap;
        forever begin
            if (sink_hold > 0) begin
                gap = sink_hold;
                sink_hold = 0;
            end else begin
                gap = sink_idle_en ? $urandom_range(0, 3) : 0;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // every result transaction is compared with the oldest predicted match address
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_match_addr.size() == 0) begin
                flag_error($sformatf("unexpected match_address %08h", m_axis_tdata));
            end else begin
                want_addr = pending_match_addr.pop_front();
                if (m_axis_tdata !== want_addr)
                    flag_error($sformatf("match_address mismatch: expected %08h, got %08h",
                                         want_addr, m_axis_tdata));
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : main_seq
        int n;
        for (int k = 0; k < DEPTH; k++) win[k] = '0;
        fill    = 0;
        len_reg = 7'd1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_byte();
        test_multi_byte();
        test_full_length();
        test_backpressure();
        test_random_scan();

        // drain, bounded, then give the pipe time to show anything extra
        s_axis_tvalid <= 1'b0;
        for (n = 0; n < 2000 && pending_match_addr.size() != 0; n++) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_match_addr.size() != 0)
            flag_error($sformatf("%0d expected match addresses never arrived",
                                 pending_match_addr.size()));

        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ byte_pattern_scanner.f @@
+incdir+rtl
rtl/bps_pkg.sv
rtl/bps_cell.sv
rtl/bps_align.sv
rtl/byte_pattern_scanner.sv
tb/tb_byte_pattern_scanner.sv
